// ===== hw/rtl/gap_pkg.sv =====
// ----------------------------------------------------------------------------
// gap_pkg
// Shared widths, limits and register codes for the global average pool.
// ----------------------------------------------------------------------------
package gap_pkg;

    localparam int MAX_SIDE     = 256;
    localparam int MAX_CHANNELS = 4096;
    localparam int SAMPLE_BITS  = 16;

    localparam int SIDE_W   = 9;
    localparam int CHAN_W   = 13;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 16;
    localparam int AREA_W   = 17;
    localparam int SUM_W    = 33;
    localparam int MAG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH     = 2'd0,
        REG_MAP_HEIGHT    = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_reg_t;

    // Request towards the divider and its answer.
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [AREA_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/gap_div.sv =====
// ----------------------------------------------------------------------------
// gap_div
// Restoring divider, one quotient bit per cycle, signed dividend truncated
// toward zero. The quotient holds until the next request.
// ----------------------------------------------------------------------------
module gap_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  gap_pkg::div_req_t req,
    output gap_pkg::div_rsp_t rsp
);
    import gap_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [AREA_W-1:0]   rem_reg, rem_next;
    logic [MAG_W-1:0]    quo_reg, quo_next;
    logic [AREA_W-1:0]   dsr_reg, dsr_next;
    logic                neg_reg, neg_next;

    logic [MAG_W-1:0]    mag;
    logic [AREA_W:0]     trial;
    logic                fits;

    always_comb begin
        // The largest magnitude, 2^31, still fits in the unsigned magnitude.
        mag   = req.dividend[SUM_W-1] ? MAG_W'(-req.dividend) : MAG_W'(req.dividend);
        trial = {rem_reg, quo_reg[MAG_W-1]};
        fits  = trial >= {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;

        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = mag;
            dsr_next  = req.divisor;
            neg_next  = req.dividend[SUM_W-1];
        end else if (busy_reg) begin
            rem_next  = fits ? AREA_W'(trial - {1'b0, dsr_reg}) : trial[AREA_W-1:0];
            quo_next  = {quo_reg[MAG_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
    end

    // The magnitude of the mean never exceeds the sample range, so the low
    // bits carry the whole quotient.
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? SAMPLE_BITS'(~quo_reg[SAMPLE_BITS-1:0] + 1'b1)
                                  : quo_reg[SAMPLE_BITS-1:0];

endmodule

// ===== hw/rtl/global_average_pool.sv =====
// ----------------------------------------------------------------------------
// global_average_pool
// Global average pooling over channel-major samples, one mean per channel.
// ----------------------------------------------------------------------------
// Samples within a channel are taken one per cycle. The last sample of a
// channel starts a 32-step restoring division, one bit per cycle, and the
// mean is loaded into the output register once the division is done. The
// input is stalled while the divider runs, or while a finished mean waits
// for the output register to empty. Synchronous active-low reset clears the
// sums, counters and handshake state and sets the registers to 1.
module global_average_pool (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gap_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gap_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Sample stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gap_pkg::SAMPLE_BITS-1:0]      s_tdata,   // [15:0] sample
    // Channel means
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gap_pkg::OUT_DATA_W-1:0]       m_tdata,   // [15:0] average,
                                                            // [27:16] channel_index,
                                                            // [31:28] zero
    output logic                                 m_tlast    // image_done
);
    import gap_pkg::*;

    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_DIV  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [SIDE_W-1:0]        width_reg, height_reg;
    logic [CHAN_W-1:0]        chans_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  fin_sum_reg, fin_sum_next;
    logic [COUNT_W-1:0]       cnt_reg, cnt_next;
    logic [INDEX_W-1:0]       chan_reg, chan_next;
    logic [INDEX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                     pend_last_reg, pend_last_next;
    logic                     start_reg, start_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]   out_avg_reg, out_avg_next;
    logic [INDEX_W-1:0]       out_idx_reg, out_idx_next;
    logic                     out_last_reg, out_last_next;

    logic [SIDE_W-1:0]        w_eff, h_eff;
    logic [CHAN_W-1:0]        c_eff;
    logic [AREA_W-1:0]        area;
    logic [AREA_W-1:0]        cnt_inc;
    logic signed [SUM_W-1:0]  sum_acc;
    logic                     chan_end, img_last, s_accept, out_free, load_out;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        if (v == '0)                       return SIDE_W'(1);
        else if (v > SIDE_W'(MAX_SIDE))    return SIDE_W'(MAX_SIDE);
        else                               return v;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
        if (v == '0)                         return CHAN_W'(1);
        else if (v > CHAN_W'(MAX_CHANNELS))  return CHAN_W'(MAX_CHANNELS);
        else                                 return v;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIDE_W'(1);
            height_reg <= SIDE_W'(1);
            chans_reg  <= CHAN_W'(1);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_MAP_WIDTH:     width_reg  <= cfg_data[SIDE_W-1:0];
                REG_MAP_HEIGHT:    height_reg <= cfg_data[SIDE_W-1:0];
                REG_CHANNEL_COUNT: chans_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    gap_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_req.start    = start_reg;
    assign div_req.dividend = fin_sum_reg;
    assign div_req.divisor  = area;

    always_comb begin
        w_eff    = clamp_side(width_reg);
        h_eff    = clamp_side(height_reg);
        c_eff    = clamp_chan(chans_reg);
        area     = AREA_W'(w_eff) * AREA_W'(h_eff);
        cnt_inc  = {1'b0, cnt_reg} + AREA_W'(1);
        chan_end = cnt_inc >= area;
        img_last = ({1'b0, chan_reg} + CHAN_W'(1)) >= c_eff;
        sum_acc  = sum_reg + SUM_W'($signed(s_tdata));
        s_accept = s_tvalid && (state_reg == ST_ACC);
        out_free = !out_valid_reg || m_tready;

        state_next     = state_reg;
        sum_next       = sum_reg;
        fin_sum_next   = fin_sum_reg;
        cnt_next       = cnt_reg;
        chan_next      = chan_reg;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        start_next     = 1'b0;
        load_out       = 1'b0;

        case (state_reg)
            ST_ACC: begin
                if (s_accept) begin
                    if (chan_end) begin
                        fin_sum_next   = sum_acc;
                        sum_next       = '0;
                        cnt_next       = '0;
                        pend_idx_next  = chan_reg;
                        pend_last_next = img_last;
                        chan_next      = img_last ? '0 : chan_reg + INDEX_W'(1);
                        start_next     = 1'b1;
                        state_next     = ST_DIV;
                    end else begin
                        sum_next = sum_acc;
                        cnt_next = cnt_inc[COUNT_W-1:0];
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_ACC;
                    end else begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase

        out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_avg_next   = load_out ? div_rsp.quotient : out_avg_reg;
        out_idx_next   = load_out ? pend_idx_reg     : out_idx_reg;
        out_last_next  = load_out ? pend_last_reg    : out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            chan_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            chan_reg      <= chan_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
        fin_sum_reg   <= fin_sum_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        out_avg_reg   <= out_avg_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == ST_ACC);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - INDEX_W - SAMPLE_BITS)'(0), out_idx_reg, out_avg_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/gap_checker.sv =====
// ----------------------------------------------------------------------------
// gap_checker
// Port-level checks on the global average pool, bound to the top level.
// ----------------------------------------------------------------------------
module gap_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gap_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              m_tlast
);
    import gap_pkg::*;

    // A stalled mean keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A new mean only follows a division, during which samples are refused.
    a_out_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a division");

    // Reset leaves the block empty and ready for samples.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // The padding above the channel index stays clear.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:INDEX_W+SAMPLE_BITS] == '0)
        else $error("result padding not zero");

endmodule

bind global_average_pool gap_checker u_gap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the global average pool. Samples are streamed in
// with random gaps, and each channel mean is predicted from a running sum at
// the moment its last sample is taken. The means that come out are compared
// field by field, in order, while the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
    import gap_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;    // divider latency plus margin
    localparam int unsigned LONG_HOLD = 500;
    localparam int unsigned RANDOM_ITEMS = 350;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic [INDEX_W-1:0]     channel_index;
        logic                   image_done;
    } channel_mean_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;

    // Predictor state and its copy of the registers.
    logic [SIDE_W-1:0]       reg_width;
    logic [SIDE_W-1:0]       reg_height;
    logic [CHAN_W-1:0]       reg_channels;
    logic signed [SUM_W-1:0] pooled_sum;
    logic [COUNT_W-1:0]      taken_in_channel;
    logic [INDEX_W-1:0]      channel_pos;

    logic [SAMPLE_BITS-1:0] sample_queue[$];
    channel_mean_t          pending_means[$];
    int unsigned            samples_queued = 0;
    int unsigned            samples_accepted = 0;
    int unsigned            means_seen = 0;
    int unsigned            mismatches = 0;
    int unsigned            cycle_count = 0;

    int unsigned send_gap = 0;
    int unsigned send_steady = 0;
    int unsigned stall_left = 0;
    int unsigned recv_steady = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    global_average_pool dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned steady_run();
        return ($urandom_range(0, 39) == 0) ? $urandom_range(20, 100) : 0;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return SAMPLE_BITS'($urandom);
        end else if (r < 80) begin
            case ($urandom_range(0, 4))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                3: return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        // Small values make the rounding of the quotient visible.
        return SAMPLE_BITS'($urandom_range(0, 16) - 8);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_side(bit allow_big);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70 || (!allow_big && r >= 90)) begin
            return CFG_DATA_W'($urandom_range(1, 4));
        end else if (r < 85) begin
            return CFG_DATA_W'($urandom_range(5, 16));
        end else if (r < 97) begin
            return '0;
        end else if (r < 99) begin
            return CFG_DATA_W'(MAX_SIDE);
        end
        return CFG_DATA_W'($urandom);
    endfunction

    function automatic void accumulate_sample(logic [SAMPLE_BITS-1:0] raw);
        int unsigned   area;
        int unsigned   chans;
        longint        mean;
        bit            ends_image;
        channel_mean_t m;
        area = clamp_to(reg_width, MAX_SIDE) * clamp_to(reg_height, MAX_SIDE);
        chans = clamp_to(reg_channels, MAX_CHANNELS);
        pooled_sum = pooled_sum + $signed(raw);
        // A shrunken area ends the channel on the next sample.
        if (taken_in_channel + 1 < area) begin
            taken_in_channel = taken_in_channel + 1'b1;
            return;
        end
        mean = longint'(pooled_sum) / longint'(area);
        ends_image = (channel_pos + 1 >= chans);
        m.average = mean[SAMPLE_BITS-1:0];
        m.channel_index = channel_pos;
        m.image_done = ends_image;
        pending_means.push_back(m);
        pooled_sum = '0;
        taken_in_channel = '0;
        channel_pos = ends_image ? '0 : channel_pos + 1'b1;
    endfunction

    function automatic void check_field(string field, longint expected, longint actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            mismatches++;
        end
    endfunction

    // Sample driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                s_tdata <= sample_queue.pop_front();
                s_tvalid <= 1'b1;
                if (send_steady > 0) begin
                    send_steady--;
                    send_gap = 0;
                end else begin
                    send_steady = steady_run();
                    send_gap = (send_steady > 0) ? 0 : idle_gap();
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, and one long hold so that the block backs up.
    always @(posedge aclk) begin : receiver
        int unsigned g;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && means_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            g = 0;
            if ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0) begin
                if (recv_steady > 0) begin
                    recv_steady--;
                end else begin
                    recv_steady = steady_run();
                    if (recv_steady == 0) begin
                        g = idle_gap();
                    end
                end
            end
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall_left = g - 1;
            end
        end
    end

    // Monitor: follows register writes and samples, checks every mean.
    always @(posedge aclk) begin : monitor
        channel_mean_t want;
        if (!aresetn) begin
            reg_width = 1;
            reg_height = 1;
            reg_channels = 1;
            pooled_sum = '0;
            taken_in_channel = '0;
            channel_pos = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAP_WIDTH:     reg_width = cfg_data[SIDE_W-1:0];
                    REG_MAP_HEIGHT:    reg_height = cfg_data[SIDE_W-1:0];
                    REG_CHANNEL_COUNT: reg_channels = cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                accumulate_sample(s_tdata);
                samples_accepted++;
            end
            if (m_tvalid && m_tready) begin
                means_seen <= means_seen + 1;
                if (pending_means.size() == 0) begin
                    $error("unexpected mean: average %0d, channel_index %0d, image_done %0d",
                           $signed(m_tdata[15:0]), m_tdata[27:16], m_tlast);
                    mismatches++;
                end else begin
                    want = pending_means.pop_front();
                    check_field("average", $signed(want.average), $signed(m_tdata[15:0]));
                    check_field("channel_index", want.channel_index, m_tdata[27:16]);
                    check_field("image_done", want.image_done, m_tlast);
                    check_field("tdata padding", 0, m_tdata[31:28]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_sample(logic [SAMPLE_BITS-1:0] v);
        sample_queue.push_back(v);
        samples_queued++;
    endtask

    // Waits until every sample is in and every mean is out, then lets the
    // divider run dry before anything else happens.
    task automatic settle();
        while (samples_accepted != samples_queued || pending_means.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned             random_items;
        int unsigned             area;
        int unsigned             n;
        logic [CFG_DATA_W-1:0]   wv;
        logic [CFG_DATA_W-1:0]   hv;
        logic [CFG_DATA_W-1:0]   tmp;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset sizes: every sample is its own channel and its own image.
        push_sample(16'h0000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        settle();

        // Pairs: full-scale sums and truncation toward zero on both signs.
        write_register(REG_MAP_WIDTH, 13'd2);
        write_register(REG_CHANNEL_COUNT, 13'd3);
        push_sample(16'h7FFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'h0003);
        push_sample(16'h0000);
        push_sample(16'hFFFD);
        push_sample(16'h0000);
        settle();

        // Area shrinks below the count already taken in the channel.
        write_register(REG_MAP_WIDTH, 13'd4);
        push_sample(16'h0001);
        push_sample(16'h0002);
        push_sample(16'h0003);
        settle();
        write_register(REG_MAP_WIDTH, 13'd2);
        push_sample(16'h0004);
        settle();

        // Channel count drops below the current channel in mid-image.
        push_sample(16'h0010);
        push_sample(16'hFFF0);
        settle();
        write_register(REG_CHANNEL_COUNT, 13'd1);
        push_sample(16'h0100);
        push_sample(16'h0101);
        settle();

        // Zero sizes behave as one; the spare register index is ignored.
        write_register(REG_MAP_WIDTH, 13'd0);
        write_register(REG_MAP_HEIGHT, 13'd0);
        write_register(REG_CHANNEL_COUNT, 13'd0);
        write_register(REG_UNUSED, 13'h1FFF);
        push_sample(16'h1234);
        push_sample(16'hEDCC);
        settle();

        // Channel count above the maximum: the image does not end early.
        write_register(REG_CHANNEL_COUNT, 13'h1FFF);
        repeat (64) push_sample(pick_sample());
        settle();

        // An oversized width is held to the largest side, with the most
        // negative sum that channel can reach.
        write_register(REG_MAP_WIDTH, 13'h1FFF);
        write_register(REG_MAP_HEIGHT, 13'd1);
        write_register(REG_CHANNEL_COUNT, 13'd1);
        repeat (MAX_SIDE) push_sample(16'h8000);
        settle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            wv = pick_side(1'b1);
            hv = pick_side(1'b0);
            if ($urandom_range(0, 1) == 1) begin
                tmp = wv;
                wv = hv;
                hv = tmp;
            end
            write_register(REG_MAP_WIDTH, wv);
            write_register(REG_MAP_HEIGHT, hv);
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       write_register(REG_CHANNEL_COUNT, '0);
                    1:       write_register(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom));
                    2, 3, 4: write_register(REG_CHANNEL_COUNT,
                                            CFG_DATA_W'($urandom_range(5, 12)));
                    default: write_register(REG_CHANNEL_COUNT,
                                            CFG_DATA_W'($urandom_range(1, 4)));
                endcase
            end
            area = clamp_to(wv[SIDE_W-1:0], MAX_SIDE) * clamp_to(hv[SIDE_W-1:0], MAX_SIDE);
            // The count often stops part way through a channel or an image.
            if (area > 64) begin
                n = area * $urandom_range(1, 2) + $urandom_range(0, 3);
            end else begin
                n = $urandom_range(1, 3 * area + 2);
            end
            // Large channels are cut short near the end of the item budget.
            if (random_items + n > RANDOM_ITEMS) begin
                n = RANDOM_ITEMS - random_items + $urandom_range(0, 3);
            end
            repeat (n) push_sample(pick_sample());
            random_items += n;
            settle();
        end

        if (mismatches == 0 && pending_means.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
